>>> src/light_sensor_autorange_lux_unit_macros.svh
// ----------------------------------------------------------------------------
// light_sensor_autorange_lux_unit_macros
// Assertion shorthands used by the lux unit.
// ----------------------------------------------------------------------------
`ifndef LIGHT_SENSOR_AUTORANGE_LUX_UNIT_MACROS_SVH
`define LIGHT_SENSOR_AUTORANGE_LUX_UNIT_MACROS_SVH

// same-cycle implication, checked on rising clk, off during reset
`define LSAL_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lux unit assertion failed");

// next-cycle implication
`define LSAL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lux unit assertion failed");

`endif

>>> src/lsal_pkg.sv
// ----------------------------------------------------------------------------
// lsal_pkg
// Shared types, register codes and constants of the auto-ranging lux unit.
// ----------------------------------------------------------------------------
package lsal_pkg;

  localparam int LUX_W     = 40;
  localparam int APB_ADDR_W = 5;
  localparam int LANE_DEPTH = 15;

  // register indexes (byte address / 4)
  localparam logic [2:0] REG_AUTO_RANGING   = 3'd0;
  localparam logic [2:0] REG_COMP_ENABLE    = 3'd1;
  localparam logic [2:0] REG_GLASS_FACTOR   = 3'd2;
  localparam logic [2:0] REG_LOW_THRESHOLD  = 3'd3;
  localparam logic [2:0] REG_HIGH_THRESHOLD = 3'd4;

  localparam logic [1:0] GAIN_MAX = 2'd3;
  localparam logic [2:0] TIME_MAX = 3'd5;
  localparam logic [4:0] SHIFT_BASE = 5'd14;

  // floor(2^30 / 625), quotient may come out one low
  localparam logic [20:0] RECIP_625 = 21'd1717986;
  localparam logic [9:0]  DIV_625   = 10'd625;
  localparam logic [8:0]  DIV_ROUND = 9'd312;

  // compensation polynomial coefficients
  localparam logic [19:0] COMP_A = 20'd693309;
  localparam logic [21:0] COMP_B = 22'd2643726;
  localparam logic [34:0] COMP_C = 35'd22936832902;
  localparam logic [32:0] COMP_D = 33'd4304845721;
  localparam logic [32:0] COMP_KNEE = 33'd65536000; // 1000 lux in Q16

  typedef struct packed {
    logic [4:0] shift;     // e + 14
    logic       low_gain;  // gain 1/8 or 1/4
  } lsal_scale_t;

  typedef struct packed {
    logic        comp_en;
    logic [15:0] glass;
  } lsal_cfg_t;

  typedef struct packed {
    logic       adjust;
    logic [1:0] gain;
    logic [2:0] tcode;
  } lsal_ctl_t;

  function automatic logic [2:0] gain_exp(input logic [1:0] g);
    logic [2:0] r;
    case (g)
      2'd0:    r = 3'd4;
      2'd1:    r = 3'd3;
      2'd2:    r = 3'd1;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

  // 2^k mod 625
  function automatic logic [9:0] pow2_mod625(input logic [4:0] k);
    logic [9:0] r;
    case (k)
      5'd14:   r = 10'd134;
      5'd15:   r = 10'd268;
      5'd16:   r = 10'd536;
      5'd17:   r = 10'd447;
      5'd18:   r = 10'd269;
      5'd19:   r = 10'd538;
      5'd20:   r = 10'd451;
      5'd21:   r = 10'd277;
      5'd22:   r = 10'd554;
      5'd23:   r = 10'd483;
      default: r = 10'd0;
    endcase
    return r;
  endfunction

  // floor(2^k / 625)
  function automatic logic [13:0] pow2_div625(input logic [4:0] k);
    logic [13:0] r;
    case (k)
      5'd14:   r = 14'd26;
      5'd15:   r = 14'd52;
      5'd16:   r = 14'd104;
      5'd17:   r = 14'd209;
      5'd18:   r = 14'd419;
      5'd19:   r = 14'd838;
      5'd20:   r = 14'd1677;
      5'd21:   r = 14'd3355;
      5'd22:   r = 14'd6710;
      5'd23:   r = 14'd13421;
      default: r = 14'd0;
    endcase
    return r;
  endfunction

endpackage

>>> src/lsal_chan.sv
// ----------------------------------------------------------------------------
// lsal_chan
// One channel of the lux datapath: count to Q16 lux, optional nonlinearity
// correction, glass factor, rounding and saturation. 15 register stages.
// ----------------------------------------------------------------------------
module lsal_chan #(
  parameter int LUX_FRACTION_BITS = 8
) (
  input  logic                    clk,
  input  logic                    en,
  input  lsal_pkg::lsal_cfg_t     cfg,
  input  lsal_pkg::lsal_scale_t   scale,
  input  logic [15:0]             count,
  output logic [lsal_pkg::LUX_W-1:0] lux
);
  import lsal_pkg::*;

  localparam int SH = 24 - LUX_FRACTION_BITS;
  localparam logic [65:0] RND = 66'(1) << (SH - 1);

  // stage 1: v = 9*count, first quotient estimate of v/625
  logic [19:0] v_in;
  logic [40:0] q1_prod;
  logic [19:0] s1_v;
  logic [9:0]  s1_q;
  logic [4:0]  s1_k, s2_k;
  logic        s1_low, s2_low, s3_low, s4_low, s5_low;

  assign v_in    = 20'({count, 3'b000}) + 20'(count);
  assign q1_prod = 41'(v_in) * 41'(RECIP_625);

  always_ff @(posedge clk) begin
    if (en) begin
      s1_v   <= v_in;
      s1_q   <= q1_prod[39:30];
      s1_k   <= scale.shift;
      s1_low <= scale.low_gain;
    end
  end

  // stage 2: fix the estimate, v = 625*a + b
  logic [10:0] rem2;
  logic        fix2;
  logic [9:0]  s2_a, s2_b;

  assign rem2 = 11'(s1_v - 20'(s1_q) * 20'(DIV_625));
  assign fix2 = rem2 >= 11'(DIV_625);

  always_ff @(posedge clk) begin
    if (en) begin
      s2_a   <= s1_q + 10'(fix2);
      s2_b   <= fix2 ? 10'(rem2 - 11'(DIV_625)) : rem2[9:0];
      s2_k   <= s1_k;
      s2_low <= s1_low;
    end
  end

  // stage 3: v*2^k = 625*(a*2^k + b*floor(2^k/625)) + b*(2^k mod 625)
  logic [19:0] s3_br;
  logic [23:0] s3_bc;
  logic [32:0] s3_ash;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_br  <= 20'(s2_b) * 20'(pow2_mod625(s2_k));
      s3_bc  <= 24'(s2_b) * 24'(pow2_div625(s2_k));
      s3_ash <= 33'(s2_a) << s2_k;
      s3_low <= s2_low;
    end
  end

  // stage 4: rounded quotient of the small remainder part
  logic [19:0] w4;
  logic [40:0] q4_prod;
  logic [19:0] s4_w;
  logic [9:0]  s4_q;
  logic [32:0] s4_base;

  assign w4      = s3_br + 20'(DIV_ROUND);
  assign q4_prod = 41'(w4) * 41'(RECIP_625);

  always_ff @(posedge clk) begin
    if (en) begin
      s4_w    <= w4;
      s4_q    <= q4_prod[39:30];
      s4_base <= s3_ash + 33'(s3_bc);
      s4_low  <= s3_low;
    end
  end

  // stage 5: x in Q16
  logic [10:0] rem5;
  logic [9:0]  f5;
  logic [32:0] s5_x;

  assign rem5 = 11'(s4_w - 20'(s4_q) * 20'(DIV_625));
  assign f5   = s4_q + 10'(rem5 >= 11'(DIV_625));

  always_ff @(posedge clk) begin
    if (en) begin
      s5_x   <= s4_base + 33'(f5);
      s5_low <= s4_low;
    end
  end

  // stage 6: p = A*x, split on x
  logic [35:0] s6_pl;
  logic [36:0] s6_ph;
  logic [32:0] s6_x, s7_x, s8_x, s9_x, s10_x, s11_x, s12_x;
  logic        s6_cmp, s7_cmp, s8_cmp, s9_cmp, s10_cmp, s11_cmp, s12_cmp;

  always_ff @(posedge clk) begin
    if (en) begin
      s6_pl  <= 36'(COMP_A) * 36'(s5_x[15:0]);
      s6_ph  <= 37'(COMP_A) * 37'(s5_x[32:16]);
      s6_x   <= s5_x;
      s6_cmp <= cfg.comp_en && (s5_low || (s5_x > COMP_KNEE));
    end
  end

  // stage 7: d = |p - B|
  logic [52:0] p_full;
  logic [24:0] p7;
  logic        ge7;
  logic [24:0] s7_d;
  logic        s7_ge, s8_ge;

  assign p_full = {s6_ph[36:0], 16'b0} + 53'(s6_pl);
  assign p7     = p_full[52:28];
  assign ge7    = p7 >= 25'(COMP_B);

  always_ff @(posedge clk) begin
    if (en) begin
      s7_d   <= ge7 ? (p7 - 25'(COMP_B)) : (25'(COMP_B) - p7);
      s7_ge  <= ge7;
      s7_x   <= s6_x;
      s7_cmp <= s6_cmp;
    end
  end

  // stage 8: d*x
  logic [40:0] s8_ml;
  logic [41:0] s8_mh;

  always_ff @(posedge clk) begin
    if (en) begin
      s8_ml  <= 41'(s7_d) * 41'(s7_x[15:0]);
      s8_mh  <= 42'(s7_d) * 42'(s7_x[32:16]);
      s8_ge  <= s7_ge;
      s8_x   <= s7_x;
      s8_cmp <= s7_cmp;
    end
  end

  // stage 9: q = C +/- m, floored at zero
  logic [42:0] m9;
  logic [43:0] s9_q;

  assign m9 = 43'(s8_mh) + 43'(s8_ml[40:16]);

  always_ff @(posedge clk) begin
    if (en) begin
      if (s8_ge) begin
        s9_q <= 44'(COMP_C) + 44'(m9);
      end else if (m9 < 43'(COMP_C)) begin
        s9_q <= 44'(43'(COMP_C) - m9);
      end else begin
        s9_q <= '0;
      end
      s9_x   <= s8_x;
      s9_cmp <= s8_cmp;
    end
  end

  // stage 10: (q >> 16) * x
  logic [43:0] s10_rl;
  logic [44:0] s10_rh;

  always_ff @(posedge clk) begin
    if (en) begin
      s10_rl  <= 44'(s9_q[43:16]) * 44'(s9_x[15:0]);
      s10_rh  <= 45'(s9_q[43:16]) * 45'(s9_x[32:16]);
      s10_x   <= s9_x;
      s10_cmp <= s9_cmp;
    end
  end

  // stage 11: s = r + D
  logic [45:0] r11;
  logic [46:0] s11_s;

  assign r11 = 46'(s10_rh) + 46'(s10_rl[43:16]);

  always_ff @(posedge clk) begin
    if (en) begin
      s11_s   <= 47'(r11) + 47'(COMP_D);
      s11_x   <= s10_x;
      s11_cmp <= s10_cmp;
    end
  end

  // stage 12: (s >> 16) * x
  logic [46:0] s12_tl;
  logic [47:0] s12_th;

  always_ff @(posedge clk) begin
    if (en) begin
      s12_tl  <= 47'(s11_s[46:16]) * 47'(s11_x[15:0]);
      s12_th  <= 48'(s11_s[46:16]) * 48'(s11_x[32:16]);
      s12_x   <= s11_x;
      s12_cmp <= s11_cmp;
    end
  end

  // stage 13: pick corrected or plain value
  logic [48:0] xc13;
  logic [48:0] s13_x;

  assign xc13 = 49'(s12_th) + 49'(s12_tl[46:16]);

  always_ff @(posedge clk) begin
    if (en) begin
      s13_x <= s12_cmp ? xc13 : 49'(s12_x);
    end
  end

  // stage 14: glass factor, split on x
  logic [40:0] s14_gl;
  logic [39:0] s14_gh;

  always_ff @(posedge clk) begin
    if (en) begin
      s14_gl <= 41'(s13_x[24:0]) * 41'(cfg.glass);
      s14_gh <= 40'(s13_x[48:25]) * 40'(cfg.glass);
    end
  end

  // stage 15: Q24 -> output fraction, round half up, saturate
  logic [65:0] z15;
  logic [65:0] zr15;

  assign z15  = {1'b0, s14_gh, 25'b0} + 66'(s14_gl);
  assign zr15 = (z15 + RND) >> SH;

  always_ff @(posedge clk) begin
    if (en) begin
      lux <= (|zr15[65:LUX_W]) ? {LUX_W{1'b1}} : zr15[LUX_W-1:0];
    end
  end

endmodule

>>> src/light_sensor_autorange_lux_unit.sv
// ----------------------------------------------------------------------------
// light_sensor_autorange_lux_unit
// Auto-ranging gain/time stepping and count-to-lux conversion for the light
// and white channels, with APB register access.
// ----------------------------------------------------------------------------
// Pipeline: 15 datapath stages per channel, the first loaded at the accepting
// edge, followed by the output register that drives result_valid.
// Throughput: one word per cycle while no valid result is stalled.
// A stalled result freezes the whole pipeline.
// Reset (rst, synchronous) clears all valid bits and loads register defaults.
module light_sensor_autorange_lux_unit #(
  parameter int LUX_FRACTION_BITS = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  // APB
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lsal_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  // sample channel
  input  logic                            sample_valid,
  output logic                            sample_stall,
  input  logic [15:0]                     light_count,
  input  logic [15:0]                     white_count,
  input  logic [1:0]                      gain_code,
  input  logic [2:0]                      time_code,
  // result channel
  output logic                            result_valid,
  input  logic                            result_stall,
  output logic                            adjust,
  output logic [1:0]                      next_gain_code,
  output logic [2:0]                      next_time_code,
  output logic [lsal_pkg::LUX_W-1:0]      light_lux,
  output logic [lsal_pkg::LUX_W-1:0]      white_chan_lux,
  output logic [lsal_pkg::LUX_W-1:0]      infrared_lux
);
  import lsal_pkg::*;

  `include "light_sensor_autorange_lux_unit_macros.svh"

  // ---------------- registers ----------------
  logic        auto_ranging;
  logic        compensation_enable;
  logic [15:0] glass_factor;
  logic [15:0] low_threshold;
  logic [15:0] high_threshold;
  logic [2:0]  reg_idx;
  logic        reg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign reg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      auto_ranging        <= 1'b0;
      compensation_enable <= 1'b1;
      glass_factor        <= 16'd256;
      low_threshold       <= 16'd100;
      high_threshold      <= 16'd10000;
    end else if (reg_wr) begin
      unique case (reg_idx)
        REG_AUTO_RANGING:   auto_ranging        <= pwdata[0];
        REG_COMP_ENABLE:    compensation_enable <= pwdata[0];
        REG_GLASS_FACTOR:   glass_factor        <= pwdata[15:0];
        REG_LOW_THRESHOLD:  low_threshold       <= pwdata[15:0];
        REG_HIGH_THRESHOLD: high_threshold      <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_AUTO_RANGING:   prdata = 32'(auto_ranging);
      REG_COMP_ENABLE:    prdata = 32'(compensation_enable);
      REG_GLASS_FACTOR:   prdata = 32'(glass_factor);
      REG_LOW_THRESHOLD:  prdata = 32'(low_threshold);
      REG_HIGH_THRESHOLD: prdata = 32'(high_threshold);
      default:            prdata = '0;
    endcase
  end

  // ---------------- pipeline control ----------------
  logic en;
  logic accept;

  assign en           = !(result_valid && result_stall);
  assign sample_stall = !en;
  assign accept       = sample_valid && en;

  // ---------------- range stepping ----------------
  logic [2:0]  t_cl;
  lsal_ctl_t   ctl_in;
  lsal_scale_t scale_in;
  lsal_cfg_t   cfg;

  assign t_cl = (time_code > TIME_MAX) ? TIME_MAX : time_code;

  always_comb begin
    ctl_in.adjust = 1'b0;
    ctl_in.gain   = gain_code;
    ctl_in.tcode  = t_cl;
    if (auto_ranging) begin
      // low rule wins when both thresholds are met
      if (light_count <= low_threshold) begin
        if (gain_code < GAIN_MAX) begin
          ctl_in.gain   = gain_code + 2'd1;
          ctl_in.adjust = 1'b1;
        end else if (t_cl < TIME_MAX) begin
          ctl_in.tcode  = t_cl + 3'd1;
          ctl_in.adjust = 1'b1;
        end
      end else if (light_count >= high_threshold) begin
        if (gain_code != 2'd0) begin
          ctl_in.gain   = gain_code - 2'd1;
          ctl_in.adjust = 1'b1;
        end else if (t_cl != 3'd0) begin
          ctl_in.tcode  = t_cl - 3'd1;
          ctl_in.adjust = 1'b1;
        end
      end
    end
  end

  assign scale_in.shift    = 5'(TIME_MAX - t_cl) + 5'(gain_exp(gain_code)) + SHIFT_BASE;
  assign scale_in.low_gain = !gain_code[1];
  assign cfg.comp_en       = compensation_enable;
  assign cfg.glass         = glass_factor;

  // ---------------- channel datapaths ----------------
  logic [LUX_W-1:0] lane_light, lane_white;

  lsal_chan #(.LUX_FRACTION_BITS(LUX_FRACTION_BITS)) u_light (
    .clk   (clk),
    .en    (en),
    .cfg   (cfg),
    .scale (scale_in),
    .count (light_count),
    .lux   (lane_light)
  );

  lsal_chan #(.LUX_FRACTION_BITS(LUX_FRACTION_BITS)) u_white (
    .clk   (clk),
    .en    (en),
    .cfg   (cfg),
    .scale (scale_in),
    .count (white_count),
    .lux   (lane_white)
  );

  // ---------------- control shadow pipe ----------------
  logic      vld [LANE_DEPTH];
  lsal_ctl_t ctl [LANE_DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LANE_DEPTH; i++) begin
        vld[i] <= 1'b0;
      end
    end else if (en) begin
      vld[0] <= accept;
      for (int i = 1; i < LANE_DEPTH; i++) begin
        vld[i] <= vld[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl[0] <= ctl_in;
      for (int i = 1; i < LANE_DEPTH; i++) begin
        ctl[i] <= ctl[i-1];
      end
    end
  end

  // ---------------- output register ----------------
  lsal_ctl_t        ctl_out;
  logic [LUX_W-1:0] ir_diff;

  assign ctl_out = ctl[LANE_DEPTH-1];
  assign ir_diff = (lane_white > lane_light) ? (lane_white - lane_light) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= vld[LANE_DEPTH-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      adjust         <= ctl_out.adjust;
      next_gain_code <= ctl_out.gain;
      next_time_code <= ctl_out.tcode;
      light_lux      <= ctl_out.adjust ? '0 : lane_light;
      white_chan_lux <= ctl_out.adjust ? '0 : lane_white;
      infrared_lux   <= ctl_out.adjust ? '0 : ir_diff;
    end
  end

  // ---------------- assertions ----------------
  logic out_lux_nz;

  assign out_lux_nz = (|light_lux) || (|white_chan_lux) || (|infrared_lux);

  `LSAL_ASSERT_IMPL(a_adjust_zero_lux, result_valid && adjust, !out_lux_nz)
  `LSAL_ASSERT_IMPL(a_ir_le_white, result_valid, infrared_lux <= white_chan_lux)
  `LSAL_ASSERT_IMPL(a_time_code_range, result_valid, next_time_code <= TIME_MAX)

endmodule
